FILE: hdl/deo_pkg.sv
// Shared types and constants for the difference edge operator.
// Used by every module under hdl/ except deo_checker; no dependencies.
package deo_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;

    typedef logic [PIX_W-1:0] pixel_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

FILE: hdl/deo_line_mem.sv
// Line buffer memory: one word per column holding all buffered rows.
// Synchronous read, one write port, zero sweep after reset. Uses deo_pkg.
module deo_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  deo_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     raddr,
    input  logic [AW-1:0]     waddr,
    input  logic [DW-1:0]     wdata,
    output logic [DW-1:0]     rdata,
    output logic              clearing
);
    import deo_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_busy_reg;

endmodule

FILE: hdl/deo_window.sv
// Square pixel window and opposite-pair difference strength.
// Depends on deo_pkg for the pixel type.
module deo_window #(
    parameter int WIN_SIZE = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  shift_en,
    input  logic [WIN_SIZE-1:0][deo_pkg::PIX_W-1:0] column,
    output deo_pkg::pixel_t                       strength
);
    import deo_pkg::*;

    localparam int WIN_LEN = WIN_SIZE * WIN_SIZE;
    localparam int NP      = WIN_LEN / 2;
    localparam int LV      = $clog2(NP);
    localparam int NP2     = 1 << LV;

    pixel_t win_reg [WIN_SIZE][WIN_SIZE];
    pixel_t tree [LV+1][NP2];

    // rows shift left, newest column enters at the right edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < WIN_SIZE; r++) begin
                for (int c = 0; c < WIN_SIZE; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (shift_en) begin
            for (int r = 0; r < WIN_SIZE; r++) begin
                for (int c = 0; c < WIN_SIZE - 1; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][WIN_SIZE-1] <= column[r];
            end
        end
    end

    // raster index s pairs with WIN_LEN-1-s; max over a balanced tree
    always_comb begin
        for (int l = 0; l <= LV; l++) begin
            for (int i = 0; i < NP2; i++) begin
                tree[l][i] = '0;
            end
        end
        for (int s = 0; s < NP; s++) begin
            if (win_reg[s / WIN_SIZE][s % WIN_SIZE] >
                win_reg[(WIN_LEN-1-s) / WIN_SIZE][(WIN_LEN-1-s) % WIN_SIZE]) begin
                tree[0][s] = win_reg[s / WIN_SIZE][s % WIN_SIZE] -
                    win_reg[(WIN_LEN-1-s) / WIN_SIZE][(WIN_LEN-1-s) % WIN_SIZE];
            end else begin
                tree[0][s] = win_reg[(WIN_LEN-1-s) / WIN_SIZE][(WIN_LEN-1-s) % WIN_SIZE] -
                    win_reg[s / WIN_SIZE][s % WIN_SIZE];
            end
        end
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < (NP2 >> (l + 1)); i++) begin
                tree[l+1][i] = (tree[l][2*i] > tree[l][2*i+1]) ? tree[l][2*i]
                                                                : tree[l][2*i+1];
            end
        end
    end

    assign strength = tree[LV][0];

endmodule

FILE: hdl/difference_edge_operator_top.sv
// Difference edge operator top: counters, line memory read-modify-write, pipeline.
// Result passes the s1, s2 and output registers; one pixel per cycle sustained unless
// m_tready stalls, set by the single read and write port of the line memory (same-column
// access forwarded). aresetn is synchronous, active low; afterwards the line memory is
// zeroed with s_tready low. Configuration writes are taken throughout.
module difference_edge_operator_top #(
    parameter int WIN_SIZE  = 3,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] pixel
    input  logic [0:0]                 s_tuser,   // [0] frame_start
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] edge_res
    output logic [0:0]                 m_tuser,   // [0] window_valid
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [deo_pkg::APB_AW-1:0] paddr,
    input  logic [deo_pkg::APB_DW-1:0] pwdata,
    output logic [deo_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import deo_pkg::*;

    localparam int LINES  = WIN_SIZE - 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(WIN_SIZE);
    localparam int WW     = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int LDW    = LINES * PIX_W;

    logic [CFG_W-1:0]  width_reg;
    logic [ADDR_W-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0]     row_reg, row_next, row_eff;
    logic [WW-1:0]     w_eff, col_inc;
    logic              win_ok, wrap;

    logic              s1_valid_reg, s1_ok_reg, fwd_reg;
    pixel_t            s1_pixel_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    logic [LDW-1:0]    fwd_data_reg;
    logic              s2_valid_reg, s2_ok_reg;
    logic              m_valid_reg, m_ok_reg;
    pixel_t            m_edge_reg;

    logic              o_ready, s2_ready, s1_ready, in_acc, s1_adv, s2_adv, fwd_next;
    logic              clearing;
    mem_ctl_t          mem_ctl;
    logic [LDW-1:0]    rd_data, line_cur, new_line;
    logic [WIN_SIZE-1:0][PIX_W-1:0] column;
    pixel_t            strength;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_IMAGE_WIDTH) begin
            width_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ?
                    {{(APB_DW - CFG_W){1'b0}}, width_reg} : '0;

    // handshakes
    assign o_ready  = !m_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || o_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready && !clearing;
    assign in_acc   = s_tvalid && s_tready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s2_adv   = s2_valid_reg && o_ready;

    // position counters
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        col_eff  = s_tuser[0] ? '0 : col_reg;
        row_eff  = s_tuser[0] ? '0 : row_reg;
        win_ok   = (row_eff >= RW'(LINES)) && (col_eff >= ADDR_W'(LINES)) &&
                   (WW'(col_eff) < w_eff);
        col_inc  = WW'(col_eff) + WW'(1);
        wrap     = col_inc >= w_eff;
        col_next = wrap ? '0 : col_inc[ADDR_W-1:0];
        row_next = (wrap && row_eff < RW'(LINES)) ? row_eff + 1'b1 : row_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // column assembly and line update
    assign line_cur = fwd_reg ? fwd_data_reg : rd_data;
    assign column   = {s1_pixel_reg, line_cur};
    assign new_line = column[WIN_SIZE-1:1];
    // write of the item ahead hits the column being read now
    assign fwd_next = s1_adv && (col_eff == s1_col_reg);

    assign mem_ctl.rd_en = in_acc;
    assign mem_ctl.wr_en = s1_adv;

    deo_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (ADDR_W),
        .DW    (LDW)
    ) u_line_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .raddr    (col_eff),
        .waddr    (s1_col_reg),
        .wdata    (new_line),
        .rdata    (rd_data),
        .clearing (clearing)
    );

    deo_window #(
        .WIN_SIZE (WIN_SIZE)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s1_adv),
        .column   (column),
        .strength (strength)
    );

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (in_acc) begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= fwd_next;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_pixel_reg <= s_tdata;
            s1_col_reg   <= col_eff;
            s1_ok_reg    <= win_ok;
            fwd_data_reg <= new_line;
        end
        if (s1_adv) begin
            s2_ok_reg <= s1_ok_reg;
        end
        if (s2_adv) begin
            m_ok_reg   <= s2_ok_reg;
            m_edge_reg <= s2_ok_reg ? strength : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_edge_reg;
    assign m_tuser  = m_ok_reg;

endmodule

FILE: hdl/deo_checker.sv
// Port-level checks for difference_edge_operator_top, attached by bind.
// Depends only on the top-level port list.
module deo_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       psel,
    input logic       penable,
    input logic       pwrite,
    input logic [2:0] paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic       pready
);

    // no stale result survives reset
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // line memory sweep keeps the input closed right after reset
    a_reset_in: assert property (@(posedge aclk) $past(!aresetn) |-> !s_tready)
        else $error("input ready during line memory sweep");

    // incomplete windows carry a zero strength
    a_zero_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("nonzero edge for incomplete window");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // width register reads back what was written
    a_cfg_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 (!paddr[2])
        |-> (prdata[11:0] == $past(pwdata[11:0])))
        else $error("width register readback mismatch");

endmodule

bind difference_edge_operator_top deo_checker u_deo_checker (.*);

FILE: tb/sv/difference_edge_operator_top_tb.sv
// Testbench for difference_edge_operator_top: raster pixel requests in, edge results out.
// Keeps its own line store, window and counters to predict each result; width set over APB.
// Depends on deo_pkg (hdl/deo_pkg.sv) and the top module.
module difference_edge_operator_top_tb;
    import deo_pkg::*;

    localparam int MASK        = 3;
    localparam int MAXW        = 2048;
    localparam int LINES       = MASK - 1;
    localparam int WIN_LEN     = MASK * MASK;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        pixel_t edge_res;
        logic   window_valid;
    } edge_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;   // [7:0] pixel
    logic [0:0]          s_tuser  = '0;   // [0] frame_start
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;         // [7:0] edge_res
    logic [0:0]          m_tuser;         // [0] window_valid
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor state
    pixel_t              line_mem [LINES][MAXW];
    pixel_t              win_regs [MASK][MASK];
    int unsigned         col_pos;
    int unsigned         rows_done;
    logic [CFG_W-1:0]    width_reg;

    edge_result_t        edge_q[$];
    int                  error_count   = 0;
    int                  cycle_count   = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;

    difference_edge_operator_top #(
        .WIN_SIZE (MASK),
        .MAX_WIDTH(MAXW)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic note_error(input string what, input int expv, input int gotv);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t: %s expected %0d actual %0d", $time, what, expv, gotv);
    endtask

    always @(posedge aclk) begin
        edge_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (edge_q.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_CAP)
                    $display("%0t: result with nothing pending, expected none actual %0d/%0d",
                             $time, m_tdata, m_tuser[0]);
            end else begin
                want = edge_q.pop_front();
                if (m_tdata !== want.edge_res)
                    note_error("edge_res", want.edge_res, m_tdata);
                if (m_tuser[0] !== want.window_valid)
                    note_error("window_valid", want.window_valid, m_tuser[0]);
            end
        end
    end

    function automatic int unsigned eff_width(input logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAXW)
            return MAXW;
        return w;
    endfunction

    // Advance the model by one pixel and queue the result it should produce.
    function automatic void predict_edge(input pixel_t pix, input logic fs);
        int unsigned  eff;
        int unsigned  c;
        int           e;
        pixel_t       column [MASK];
        pixel_t       a;
        pixel_t       b;
        pixel_t       d;
        pixel_t       best;
        logic         ok;
        edge_result_t res;
        eff = eff_width(width_reg);
        if (fs) begin
            col_pos   = 0;
            rows_done = 0;
        end
        c = col_pos % MAXW;
        for (int k = 0; k < LINES; k++)
            column[k] = line_mem[k][c];
        column[MASK-1] = pix;
        for (int k = 0; k < LINES - 1; k++)
            line_mem[k][c] = line_mem[k+1][c];
        line_mem[LINES-1][c] = pix;
        for (int k = 0; k < MASK; k++) begin
            for (int t = 0; t < MASK - 1; t++)
                win_regs[k][t] = win_regs[k][t+1];
            win_regs[k][MASK-1] = column[k];
        end
        ok   = (rows_done >= LINES) && (c >= LINES) && (c < eff);
        best = '0;
        if (ok) begin
            // raster element s faces element WIN_LEN-1-s through the center
            for (int s = 0; s < WIN_LEN / 2; s++) begin
                e = WIN_LEN - 1 - s;
                a = win_regs[s / MASK][s % MASK];
                b = win_regs[e / MASK][e % MASK];
                d = (a > b) ? a - b : b - a;
                if (d > best)
                    best = d;
            end
        end
        res.edge_res     = best;
        res.window_valid = ok;
        edge_q.insert(edge_q.size(), res);
        c++;
        if (c >= eff) begin
            c = 0;
            if (rows_done < LINES)
                rows_done++;
        end
        col_pos = c;
    endfunction

    task automatic send_pixel(input pixel_t pix, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= pix;
        s_tuser[0] <= fs;
        do @(posedge aclk); while (!s_tready);
        predict_edge(pix, fs);
    endtask

    // Stop sending and let every pending result drain, plus pipeline slack.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (edge_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_read(input reg_idx_t idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            note_error("image_width readback", want, got);
    endtask

    task automatic set_width(input logic [APB_DW-1:0] data);
        wait_for_idle();
        apb_write(REG_IMAGE_WIDTH, data);
        width_reg = data[CFG_W-1:0];
        @(posedge aclk);
        apb_check_read(REG_IMAGE_WIDTH, {{(APB_DW-CFG_W){1'b0}}, data[CFG_W-1:0]});
    endtask

    function automatic pixel_t make_pixel(input int style, input pixel_t base);
        case (style)
            0:       return pixel_t'($urandom_range(255));
            1:       return pixel_t'(int'(base) + int'($urandom_range(6)) - 3);
            default: return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic test_reset_state();
        apb_check_read(REG_IMAGE_WIDTH, {{(APB_DW-CFG_W){1'b0}}, WIDTH_RESET});
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h01, 1'b0);
    endtask

    task automatic test_small_frame();
        pixel_t rows [12] = '{8'h00, 8'hFF, 8'h00,
                              8'hFF, 8'h00, 8'hFF,
                              8'h00, 8'hFF, 8'hFF,
                              8'hFF, 8'hFF, 8'hFF};
        set_width(32'd3);
        for (int k = 0; k < 12; k++)
            send_pixel(rows[k], k == 0);
    endtask

    // widths below the mask never form a window; upper data lines must be dropped
    task automatic test_narrow_widths();
        set_width(32'hFFFF_F000);
        for (int k = 0; k < 3; k++)
            send_pixel(8'hFF, k == 0);
        set_width(32'd1);
        for (int k = 0; k < 3; k++)
            send_pixel(8'h00, 1'b0);
        set_width(32'd2);
        for (int k = 0; k < 6; k++)
            send_pixel(k[0] ? 8'hFF : 8'h00, k == 1);
    endtask

    task automatic test_frame_restart();
        set_width(32'd4);
        for (int k = 0; k < 10; k++)
            send_pixel(pixel_t'($urandom_range(255)), k == 0);
        // restart mid-row: counters clear, stale lines must not make a window valid
        for (int k = 0; k < 13; k++)
            send_pixel(pixel_t'($urandom_range(255)), k == 0);
    endtask

    task automatic test_width_change();
        set_width(32'd8);
        for (int k = 0; k < 14; k++)
            send_pixel(pixel_t'($urandom_range(255)), k == 0);
        // column now past the new width: wraps and counts the row as done
        set_width(32'd4);
        for (int k = 0; k < 10; k++)
            send_pixel(pixel_t'($urandom_range(255)), 1'b0);
        set_width(32'd5);
        for (int k = 0; k < 8; k++)
            send_pixel(pixel_t'($urandom_range(255)), 1'b0);
    endtask

    // oversized and largest widths must not wrap early; a narrow width then ends the row
    task automatic test_max_width();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_width(32'h0000_0FFF);
        for (int k = 0; k < 24; k++)
            send_pixel(pixel_t'($urandom_range(255)), k == 0);
        set_width(32'd3);
        for (int k = 0; k < 9; k++)
            send_pixel(pixel_t'($urandom_range(255)), 1'b0);
        set_width(32'd2048);
        for (int k = 0; k < 24; k++)
            send_pixel(pixel_t'($urandom_range(255)), k == 0);
        set_width(32'd3);
        for (int k = 0; k < 9; k++)
            send_pixel(pixel_t'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_random_frames(input int send_pct, input int recv_pct, input int target);
        int          sent;
        int unsigned eff;
        int unsigned npix;
        int unsigned cut;
        int          style;
        logic        fs;
        pixel_t      base;
        logic [CFG_W-1:0] w;
        sent          = 0;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        while (sent < target) begin
            case ($urandom_range(19))
                0:       w = CFG_W'($urandom_range(2));
                1, 2:    w = CFG_W'($urandom_range(13, 64));
                default: w = CFG_W'($urandom_range(3, 12));
            endcase
            set_width({$urandom_range(1) ? 20'hFFFFF : 20'h00000, w});
            repeat ($urandom_range(1, 3)) begin
                eff   = eff_width(w);
                npix  = $urandom_range(3, 5) * eff;
                cut   = ($urandom_range(9) == 0) ? $urandom_range(1, npix) : npix;
                style = $urandom_range(2);
                base  = pixel_t'($urandom_range(255));
                for (int unsigned k = 0; k < cut; k++) begin
                    // mostly clean frames; sometimes no start mark or a stray one
                    fs = (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(199) == 0);
                    send_pixel(make_pixel(style, base), fs);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        for (int k = 0; k < LINES; k++)
            for (int j = 0; j < MAXW; j++)
                line_mem[k][j] = '0;
        for (int k = 0; k < MASK; k++)
            for (int j = 0; j < MASK; j++)
                win_regs[k][j] = '0;
        col_pos   = 0;
        rows_done = 0;
        width_reg = WIDTH_RESET;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_small_frame();
        test_narrow_widths();
        test_frame_restart();
        test_width_change();
        test_max_width();
        test_random_frames(0, 0, 400);
        test_random_frames(46, 0, 400);
        test_random_frames(0, 46, 400);
        test_random_frames(35, 35, 400);

        wait_for_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
